// ===== rtl/wavhp_pkg.sv =====
package wavhp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [15:0] format_code;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [15:0] sample_bits;
		logic [15:0] frame_bytes;
		logic [31:0] payload_size;
		logic [31:0] payload_offset;
		logic [31:0] frame_total;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [12:0] {
		PH_WAIT     = 13'b0000000000001,
		PH_RIFF     = 13'b0000000000010,
		PH_RSIZE    = 13'b0000000000100,
		PH_WAVE     = 13'b0000000001000,
		PH_CKID     = 13'b0000000010000,
		PH_SZ_FMT   = 13'b0000000100000,
		PH_SZ_DATA  = 13'b0000001000000,
		PH_SZ_OTHER = 13'b0000010000000,
		PH_FMT      = 13'b0000100000000,
		PH_CB       = 13'b0001000000000,
		PH_EXT      = 13'b0010000000000,
		PH_SKIP     = 13'b0100000000000,
		PH_DONE     = 13'b1000000000000
	} phase_t;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [15:0] EXTENSIBLE_TAG = 16'hFFFE;
	localparam logic [31:0] EXT_CONSUMED = 32'd40;
	localparam logic [15:0] EXT_MIN_SIZE = 16'd22;
	localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
	localparam logic [15:0] FMT_PCM = 16'd1;
	localparam logic [15:0] FMT_FLOAT = 16'd3;

	localparam logic [1:0] REG_MAX_CH   = 2'd0;
	localparam logic [1:0] REG_MIN_RATE = 2'd1;
	localparam logic [1:0] REG_MAX_RATE = 2'd2;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_NO_RIFF    = 4'd1;
	localparam logic [3:0] ST_NO_WAVE    = 4'd2;
	localparam logic [3:0] ST_FMT_SMALL  = 4'd3;
	localparam logic [3:0] ST_EXT_SMALL  = 4'd4;
	localparam logic [3:0] ST_NO_FMT     = 4'd5;
	localparam logic [3:0] ST_FORMAT     = 4'd6;
	localparam logic [3:0] ST_CHANNELS   = 4'd7;
	localparam logic [3:0] ST_RATE       = 4'd8;
	localparam logic [3:0] ST_BITS       = 4'd9;
	localparam logic [3:0] ST_EARLY_END  = 4'd10;

endpackage

// ===== rtl/wavhp_div.sv =====
module wavhp_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [31:0]             dividend,
	input  logic [15:0]             divisor,
	output wavhp_pkg::div_stat_t    stat,
	output logic [31:0]             quotient
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dvs_q;
	logic        done_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so 16 bits hold it
			rem_q <= fits ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ===== rtl/riff_wave_header_parser_top.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_data  (wavhp_pkg::in_item_t)
// out     | output    | out_valid / out_ready  | out_data (wavhp_pkg::out_item_t)
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Header bytes are taken at one per cycle while in_ready is high; the parse step is combinational.
// A good header then waits for the frame count from the divider (one quotient bit
// a cycle); error results are shown without it.
// in_ready drops from result decision until the result request is taken.
// arst_n clears control state and restores the register defaults.
// cfg_ready is always high.
module riff_wave_header_parser_top #(
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  wavhp_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wavhp_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	// configuration registers
	logic [7:0]  max_ch_q;
	logic [31:0] min_rate_q;
	logic [31:0] max_rate_q;

	// parse state
	wavhp_pkg::phase_t       phase_q;
	logic [5:0]              cnt_q;
	logic [31:0]             sh_q;
	logic [31:0]             clen_q;
	logic [32:0]             skip_q;
	logic [OFFSET_WIDTH-1:0] pos_q;
	logic [15:0]             fmt_q;
	logic [15:0]             ch_q;
	logic [31:0]             rate_q;
	logic [15:0]             align_q;
	logic [15:0]             bits_q;
	logic [15:0]             ext_q;

	// result side
	logic                 out_valid_q;
	logic                 pend_q;
	wavhp_pkg::out_item_t res_q;

	// next-state values
	wavhp_pkg::phase_t       ph_b;
	wavhp_pkg::phase_t       ph_n;
	logic [5:0]              n;
	logic [31:0]             sh_n;
	logic [31:0]             clen_n;
	logic [32:0]             skip_n;
	logic [OFFSET_WIDTH-1:0] pos_n;
	logic [15:0]             fmt_n;
	logic [15:0]             ch_n;
	logic [31:0]             rate_n;
	logic [15:0]             align_n;
	logic [15:0]             bits_n;
	logic [15:0]             ext_n;
	logic [15:0]             half;
	logic                    res;
	logic [3:0]              st;
	logic [3:0]              chk;
	logic [32:0]             skv;
	logic                    do_skip;
	logic                    acc;

	wavhp_pkg::div_stat_t    dstat;
	logic [31:0]             quo;
	logic                    div_go;

	assign acc       = in_valid && in_ready;
	assign in_ready  = !out_valid_q && !pend_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ch_q   <= 8'd8;
			min_rate_q <= 32'd8000;
			max_rate_q <= 32'd192000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wavhp_pkg::REG_MAX_CH:   max_ch_q   <= cfg_data[7:0];
				wavhp_pkg::REG_MIN_RATE: min_rate_q <= cfg_data;
				wavhp_pkg::REG_MAX_RATE: max_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// format validation against held fmt values
	always_comb begin
		if (align_q == 16'd0)
			chk = wavhp_pkg::ST_NO_FMT;
		else if (fmt_q != wavhp_pkg::FMT_PCM && fmt_q != wavhp_pkg::FMT_FLOAT)
			chk = wavhp_pkg::ST_FORMAT;
		else if (ch_q == 16'd0 || ch_q > {8'd0, max_ch_q})
			chk = wavhp_pkg::ST_CHANNELS;
		else if (rate_q < min_rate_q || rate_q > max_rate_q)
			chk = wavhp_pkg::ST_RATE;
		else if (fmt_q == wavhp_pkg::FMT_PCM && bits_q != 16'd16 && bits_q != 16'd24
			&& bits_q != 16'd32)
			chk = wavhp_pkg::ST_BITS;
		else if (fmt_q == wavhp_pkg::FMT_FLOAT && bits_q != 16'd32)
			chk = wavhp_pkg::ST_BITS;
		else
			chk = wavhp_pkg::ST_OK;
	end

	always_comb begin
		// a first byte restarts from a cleared state
		ph_b    = in_data.first_byte ? wavhp_pkg::PH_RIFF : phase_q;
		n       = (in_data.first_byte ? 6'd0 : cnt_q) + 6'd1;
		sh_n    = {in_data.data_byte, (in_data.first_byte ? 24'd0 : sh_q[31:8])};
		pos_n   = (in_data.first_byte ? '0 : pos_q) + OFFSET_WIDTH'(1);
		clen_n  = in_data.first_byte ? '0 : clen_q;
		skip_n  = in_data.first_byte ? '0 : skip_q;
		fmt_n   = in_data.first_byte ? '0 : fmt_q;
		ch_n    = in_data.first_byte ? '0 : ch_q;
		rate_n  = in_data.first_byte ? '0 : rate_q;
		align_n = in_data.first_byte ? '0 : align_q;
		bits_n  = in_data.first_byte ? '0 : bits_q;
		ext_n   = in_data.first_byte ? '0 : ext_q;
		half    = sh_n[31:16];
		ph_n    = ph_b;
		res     = 1'b0;
		st      = wavhp_pkg::ST_OK;
		skv     = '0;
		do_skip = 1'b0;
		unique case (ph_b)
			wavhp_pkg::PH_RIFF: if (n == 6'd4) begin
				if (sh_n != wavhp_pkg::TAG_RIFF) begin
					res = 1'b1;
					st  = wavhp_pkg::ST_NO_RIFF;
				end else
					ph_n = wavhp_pkg::PH_RSIZE;
			end
			wavhp_pkg::PH_RSIZE: if (n == 6'd4) ph_n = wavhp_pkg::PH_WAVE;
			wavhp_pkg::PH_WAVE: if (n == 6'd4) begin
				if (sh_n != wavhp_pkg::TAG_WAVE) begin
					res = 1'b1;
					st  = wavhp_pkg::ST_NO_WAVE;
				end else
					ph_n = wavhp_pkg::PH_CKID;
			end
			wavhp_pkg::PH_CKID: if (n == 6'd4) begin
				if (sh_n == wavhp_pkg::TAG_FMT)
					ph_n = wavhp_pkg::PH_SZ_FMT;
				else if (sh_n == wavhp_pkg::TAG_DATA)
					ph_n = wavhp_pkg::PH_SZ_DATA;
				else
					ph_n = wavhp_pkg::PH_SZ_OTHER;
			end
			wavhp_pkg::PH_SZ_FMT: if (n == 6'd4) begin
				clen_n = sh_n;
				if (sh_n < wavhp_pkg::FMT_MIN_SIZE) begin
					res = 1'b1;
					st  = wavhp_pkg::ST_FMT_SMALL;
				end else
					ph_n = wavhp_pkg::PH_FMT;
			end
			wavhp_pkg::PH_SZ_DATA: if (n == 6'd4) begin
				clen_n = sh_n;
				res    = 1'b1;
				st     = chk;
			end
			wavhp_pkg::PH_SZ_OTHER: if (n == 6'd4) begin
				clen_n  = sh_n;
				// odd size carries one pad byte
				skv     = {1'b0, sh_n} + {32'd0, sh_n[0]};
				do_skip = 1'b1;
			end
			wavhp_pkg::PH_FMT: begin
				unique case (n)
					6'd2:  fmt_n   = half;
					6'd4:  ch_n    = half;
					6'd8:  rate_n  = sh_n;
					6'd14: align_n = half;
					6'd16: begin
						bits_n = half;
						if (fmt_n == wavhp_pkg::EXTENSIBLE_TAG)
							ph_n = wavhp_pkg::PH_CB;
						else begin
							skv     = {1'b0, clen_n - wavhp_pkg::FMT_MIN_SIZE};
							do_skip = 1'b1;
						end
					end
					default: ;
				endcase
			end
			wavhp_pkg::PH_CB: if (n == 6'd2) begin
				ext_n = half;
				if (half < wavhp_pkg::EXT_MIN_SIZE) begin
					res = 1'b1;
					st  = wavhp_pkg::ST_EXT_SMALL;
				end else
					ph_n = wavhp_pkg::PH_EXT;
			end
			wavhp_pkg::PH_EXT: begin
				if (n == 6'd8)
					fmt_n = half;
				else if (n == 6'd22) begin
					// saturating extension skip
					skv = (clen_n > wavhp_pkg::EXT_CONSUMED) ?
						{1'b0, clen_n - wavhp_pkg::EXT_CONSUMED} : '0;
					do_skip = 1'b1;
				end
			end
			wavhp_pkg::PH_SKIP: begin
				skip_n = skip_n - 33'd1;
				n      = '0;
				if (skip_n == '0) ph_n = wavhp_pkg::PH_CKID;
			end
			default: ;
		endcase
		if (do_skip) begin
			skip_n = skv;
			ph_n   = (skv == '0) ? wavhp_pkg::PH_CKID : wavhp_pkg::PH_SKIP;
		end
		if (ph_n != ph_b) n = '0;
		if (!res && in_data.last_byte) begin
			res = 1'b1;
			st  = wavhp_pkg::ST_EARLY_END;
		end
		if (res) begin
			ph_n = wavhp_pkg::PH_DONE;
			n    = '0;
		end
	end

	// idle phases ignore bytes unless a first byte restarts
	logic active;
	assign active = acc && ph_b != wavhp_pkg::PH_WAIT && ph_b != wavhp_pkg::PH_DONE;
	assign div_go = active && res && st == wavhp_pkg::ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= wavhp_pkg::PH_WAIT;
			cnt_q       <= '0;
			skip_q      <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (active) begin
				phase_q <= ph_n;
				cnt_q   <= n;
				skip_q  <= skip_n;
			end
			if (div_go)
				pend_q <= 1'b1;
			else if (dstat.done)
				pend_q <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			else if ((active && res && st != wavhp_pkg::ST_OK) || dstat.done)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			sh_q    <= sh_n;
			clen_q  <= clen_n;
			pos_q   <= pos_n;
			fmt_q   <= fmt_n;
			ch_q    <= ch_n;
			rate_q  <= rate_n;
			align_q <= align_n;
			bits_q  <= bits_n;
			ext_q   <= ext_n;
		end
		if (active && res) begin
			if (st == wavhp_pkg::ST_OK) begin
				res_q.status         <= st;
				res_q.format_code    <= fmt_n;
				res_q.channel_count  <= ch_n;
				res_q.rate_hz        <= rate_n;
				res_q.sample_bits    <= bits_n;
				res_q.frame_bytes    <= align_n;
				res_q.payload_size   <= clen_n;
				res_q.payload_offset <= 32'(pos_n);
				res_q.frame_total    <= '0;
			end else
				res_q <= wavhp_pkg::out_item_t'({st, 192'd0});
		end else if (dstat.done)
			res_q.frame_total <= quo;
	end

	wavhp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (clen_n),
		.divisor  (align_n),
		.stat     (dstat),
		.quotient (quo)
	);

`ifndef SYNTHESIS
	a_no_pend_and_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_q && out_valid_q))
		else $error("result shown while division pending");
	a_done_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> pend_q)
		else $error("divider finished without a pending result");
	a_go_gives_pend: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |=> pend_q && dstat.busy)
		else $error("division start lost");
	a_ext_stored: assert property (@(posedge clk) disable iff (!arst_n)
		(active && phase_q == wavhp_pkg::PH_EXT && !in_data.first_byte) |-> ext_q >= 16'd22)
		else $error("extension phase with short extension");
`endif

endmodule
